// File: rtl/ili_pkg.sv
// ----------------------------------------------------------------------------
// ili_pkg
// Shared types and codes for the indexed list block: request and status
// codes, payload structs and the control word broadcast to every cell.
// ----------------------------------------------------------------------------
package ili_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 8;
  localparam int unsigned CountW = 8;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [ValueW-1:0] item_value;
    logic [PosW-1:0]          position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [CountW-1:0] count;
  } out_item_t;

  // Control word broadcast to the row of cells
  typedef struct packed {
    logic     load;    // an item is accepted this cycle
    cell_op_t op;      // shift action of the row
    logic     search;  // capture the compare result
  } cell_ctrl_t;

endpackage

// File: rtl/ili_cell.sv
// ----------------------------------------------------------------------------
// ili_cell
// One list slot: holds an entry, takes it from the lower neighbor on insert
// or from the upper neighbor on delete, and registers its search match.
// ----------------------------------------------------------------------------
module ili_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 8
) (
  input  logic                      clk,
  input  ili_pkg::cell_ctrl_t       ctrl,
  input  logic [CW-1:0]             pos,
  input  logic [CW-1:0]             cnt,
  input  logic [ili_pkg::ValueW-1:0] value,
  input  logic [ili_pkg::ValueW-1:0] prev_entry,
  input  logic [ili_pkg::ValueW-1:0] next_entry,
  output logic [ili_pkg::ValueW-1:0] entry,
  output logic                      match
);

  localparam logic [CW:0] MyIdx = (CW+1)'(IDX);

  logic [ili_pkg::ValueW-1:0] entry_r, entry_nxt;
  logic                       match_r, match_nxt;
  logic [CW:0]                pos_x, cnt_x;

  assign pos_x = {1'b0, pos};
  assign cnt_x = {1'b0, cnt};

  always_comb begin
    entry_nxt = entry_r;
    match_nxt = match_r;
    if (ctrl.load) begin
      match_nxt = ctrl.search && (MyIdx < cnt_x) && (entry_r == value);
      unique case (ctrl.op)
        ili_pkg::CELL_INSERT: begin
          if (MyIdx == pos_x) begin
            entry_nxt = value;
          end else if (MyIdx > pos_x && MyIdx <= cnt_x) begin
            entry_nxt = prev_entry;
          end
        end
        ili_pkg::CELL_DELETE: begin
          if (MyIdx >= pos_x && (MyIdx + 1'b1) < cnt_x) begin
            entry_nxt = next_entry;
          end
        end
        default: begin
          entry_nxt = entry_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

// File: rtl/indexed_list_insert_delete_search.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_search
// Packed list with insert, delete and linear search over a row of cells.
// ----------------------------------------------------------------------------
// An accepted item moves through the s1 stage and then the output register.
// Throughput: one item per cycle unless out_ready stalls; the row of cells
// shifts and compares all entries at accept, the match OR is taken as s1 advances.
// Reset: clears the live count and both pipeline valids; entry contents are
// not cleared and are only read once written.
module indexed_list_insert_delete_search #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ili_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ili_pkg::out_item_t out_data
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned MW = (CW > ili_pkg::PosW) ? CW : ili_pkg::PosW;
  localparam logic [MW-1:0] CapW = MW'(CAPACITY);

  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           s1_valid_r, s1_valid_nxt;
  logic [1:0]     s1_status_r;
  logic [ili_pkg::CountW-1:0] s1_count_r;
  logic           out_valid_r, out_valid_nxt;
  ili_pkg::out_item_t out_data_r;

  logic           accept, s1_adv;
  logic [MW-1:0]  pos_w, cnt_w, cnt_new_w;
  logic [1:0]     status_c;
  ili_pkg::cell_ctrl_t ctrl;

  logic [ili_pkg::ValueW-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]        match_w;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  assign pos_w = MW'(in_data.position);
  assign cnt_w = MW'(cnt_r);

  // Decode request, check position and fullness
  always_comb begin
    status_c    = ili_pkg::ST_OK;
    cnt_new_w   = cnt_w;
    ctrl.load   = accept;
    ctrl.op     = ili_pkg::CELL_HOLD;
    ctrl.search = 1'b0;
    unique case (in_data.req_type)
      ili_pkg::REQ_INSERT: begin
        if (pos_w > cnt_w) begin
          status_c = ili_pkg::ST_BAD_POS;
        end else if (cnt_w >= CapW) begin
          status_c = ili_pkg::ST_FULL;
        end else begin
          ctrl.op   = ili_pkg::CELL_INSERT;
          cnt_new_w = cnt_w + 1'b1;
        end
      end
      ili_pkg::REQ_DELETE: begin
        if (pos_w >= cnt_w) begin
          status_c = ili_pkg::ST_BAD_POS;
        end else begin
          ctrl.op   = ili_pkg::CELL_DELETE;
          cnt_new_w = cnt_w - 1'b1;
        end
      end
      ili_pkg::REQ_SEARCH: begin
        ctrl.search = 1'b1;
      end
      default: begin
        status_c = ili_pkg::ST_OK;
      end
    endcase
  end

  assign cnt_nxt       = accept ? cnt_new_w[CW-1:0] : cnt_r;
  assign s1_valid_nxt  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status_c;
      s1_count_r  <= cnt_new_w[ili_pkg::CountW-1:0];
    end
    if (s1_adv) begin
      out_data_r.status <= s1_status_r;
      out_data_r.found  <= |match_w;
      out_data_r.count  <= s1_count_r;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ili_pkg::ValueW-1:0] prev_e, next_e;
    if (i == 0) begin : g_first
      assign prev_e = in_data.item_value;
    end else begin : g_prev
      assign prev_e = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_next
      assign next_e = entry_w[i+1];
    end
    ili_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (pos_w[CW-1:0]),
      .cnt        (cnt_r),
      .value      (in_data.item_value),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry      (entry_w[i]),
      .match      (match_w[i])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sim/tb_indexed_list_insert_delete_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_delete_search
// Self-checking bench for the packed list block. A scoreboard keeps its own
// copy of the list, predicts status, found and count for every accepted
// request, and compares each returned result in order. Directed requests
// cover the edges, then biased random phases fill the list to capacity,
// drain it and mix requests, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_delete_search;
  import ili_pkg::*;

  localparam int unsigned CAPACITY   = 128;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;
  localparam int unsigned HoldOffLen = 80;
  localparam int unsigned DrainWait  = 10;

  class ListScoreboard;
    logic signed [ValueW-1:0] slots [CAPACITY];
    int unsigned              used;
    out_item_t                expected_q [$];
    int unsigned              errors;

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted request to the shadow list and queue its result.
    function void note_request(in_item_t req);
      status_t     st;
      logic        hit;
      int unsigned pos;
      out_item_t   exp;
      st  = ST_OK;
      hit = 1'b0;
      pos = 32'(req.position);
      case (req.req_type)
        REQ_INSERT: begin
          if (pos > used) begin
            st = ST_BAD_POS;
          end else if (used >= CAPACITY) begin
            st = ST_FULL;
          end else begin
            for (int i = int'(used); i > int'(pos); i--) slots[i] = slots[i-1];
            slots[pos] = req.item_value;
            used++;
          end
        end
        REQ_DELETE: begin
          if (pos >= used) begin
            st = ST_BAD_POS;
          end else begin
            for (int i = int'(pos) + 1; i < int'(used); i++) slots[i-1] = slots[i];
            used--;
          end
        end
        REQ_SEARCH: begin
          for (int i = 0; i < int'(used); i++) begin
            if (slots[i] == req.item_value) hit = 1'b1;
          end
        end
        default: ;
      endcase
      exp.status = st;
      exp.found  = hit;
      exp.count  = used[CountW-1:0];
      expected_q.push_back(exp);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, got status %0d found %0d count %0d",
                 $time, got.status, got.found, got.count);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status expected %0d, got %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.found !== exp.found) begin
        $display("%0t: found expected %0d, got %0d", $time, exp.found, got.found);
        errors++;
      end
      if (got.count !== exp.count) begin
        $display("%0t: count expected %0d, got %0d", $time, exp.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  ListScoreboard sb = new();
  bit            calm;
  bit            hold_request;

  indexed_list_insert_delete_search #(.CAPACITY(CAPACITY)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldOffLen - 1;
        out_ready   <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 28);
      end
    end
  end

  function automatic in_item_t make_req(logic [1:0] kind, logic signed [ValueW-1:0] value,
                                        logic [PosW-1:0] pos);
    in_item_t it;
    it.req_type   = kind;
    it.item_value = value;
    it.position   = pos;
    return it;
  endfunction

  function automatic logic signed [ValueW-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) return $signed($urandom_range(8)) - 4;
    if (roll < 35) return {1'b1, {(ValueW-1){1'b0}}};
    if (roll < 40) return {1'b0, {(ValueW-1){1'b1}}};
    return $urandom;
  endfunction

  // Mostly valid positions for the current length, some out of range.
  function automatic in_item_t pick_request(int unsigned ins_pct, int unsigned del_pct);
    int unsigned roll;
    int unsigned len;
    in_item_t    it;
    roll = $urandom_range(99);
    len  = sb.used;
    it.item_value = pick_value();
    if ($urandom_range(99) < 8) it.position = PosW'($urandom_range(255));
    else it.position = PosW'($urandom_range(len));
    if (roll < ins_pct) begin
      it.req_type = REQ_INSERT;
    end else if (roll < ins_pct + del_pct) begin
      it.req_type = REQ_DELETE;
      if (len > 0 && $urandom_range(99) < 90) it.position = PosW'($urandom_range(len - 1));
    end else if (roll < 95) begin
      it.req_type = REQ_SEARCH;
      if (len > 0 && $urandom_range(1)) it.item_value = sb.slots[$urandom_range(len - 1)];
    end else begin
      it.req_type = REQ_UNUSED;
    end
    return it;
  endfunction

  // Enter and leave at a falling edge; valid stays high on return.
  task automatic send_item(in_item_t item);
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_request(item);
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_phase(int unsigned n, int unsigned ins_pct, int unsigned del_pct,
                           int unsigned calm_items, bit with_hold);
    for (int unsigned k = 0; k < n; k++) begin
      calm = (k < calm_items);
      if (with_hold && k == 40) hold_request = 1'b1;
      send_item(pick_request(ins_pct, del_pct));
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Edges: empty list, bad positions, extreme values, unused code.
    send_item(make_req(REQ_SEARCH, 0, 0));
    send_item(make_req(REQ_DELETE, 0, 0));
    send_item(make_req(REQ_INSERT, 7, 1));
    send_item(make_req(REQ_INSERT, 32'sh8000_0000, 0));
    send_item(make_req(REQ_INSERT, 32'sh7fff_ffff, 1));
    send_item(make_req(REQ_INSERT, -1, 0));
    send_item(make_req(REQ_INSERT, 0, 1));
    send_item(make_req(REQ_INSERT, 32'sh1234_5678, 4));
    send_item(make_req(REQ_INSERT, 9, 6));
    send_item(make_req(REQ_INSERT, 9, 255));
    send_item(make_req(REQ_INSERT, 9, 128));
    send_item(make_req(REQ_SEARCH, 32'sh8000_0000, 0));
    send_item(make_req(REQ_SEARCH, 32'sh7fff_ffff, 0));
    send_item(make_req(REQ_SEARCH, 32'sh1234_5678, 0));
    send_item(make_req(REQ_SEARCH, 5, 255));
    send_item(make_req(REQ_UNUSED, 32'sh5a5a_a5a5, 0));
    send_item(make_req(REQ_DELETE, 0, 5));
    send_item(make_req(REQ_DELETE, 0, 255));
    send_item(make_req(REQ_DELETE, 0, 4));
    send_item(make_req(REQ_SEARCH, 32'sh1234_5678, 0));
    send_item(make_req(REQ_DELETE, 0, 0));
    send_item(make_req(REQ_DELETE, 0, 1));
    send_item(make_req(REQ_SEARCH, -1, 0));
    send_item(make_req(REQ_UNUSED, -1, 255));
    send_item(make_req(REQ_SEARCH, 32'sh7fff_ffff, 0));
    pause_until_drained();

    // Fill to capacity and push against the full list, then drain and mix.
    run_phase(260, 75, 10, 0, 1'b1);
    pause_until_drained();
    run_phase(260, 10, 75, 0, 1'b0);
    run_phase(300, 40, 35, 150, 1'b1);
    pause_until_drained();
    run_phase(200, 80, 5, 0, 1'b0);
    run_phase(150, 15, 70, 0, 1'b0);

    pause_until_drained();
    repeat (DrainWait) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
